// ===== sv/scba_pkg.sv =====
// Package for the size-class bitmap allocator: request codes, status codes,
// the controller state type and the fixed page geometry. No dependencies.
package scba_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int BITMAP_WORDS = 64;
   localparam int WORD_BITS = 32;
   localparam int CLASS_W = 4;
   localparam int STAMP_W = 16;
   localparam int COUNT_W = 12;
   localparam int PAGE_W = 20;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_FRAME = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCAN_LAST,
      S_WORD_RD,
      S_WORD_CHK,
      S_FREE_RD,
      S_FREE_WR,
      S_NEW_CLR,
      S_RESP
   } state_type;

   // Class of a size: ceil(log2(size)), at least 1 (a size of zero also gives 1).
   function automatic logic [5:0] class_of(input logic [31:0] size);
      logic [5:0] msb;
      msb = '0;
      for (int i = 0; i < 32; i++) begin
         if (size[i]) begin
            msb = 6'(i);
         end
      end
      if (msb == 6'd0 || (size & ~(32'd1 << msb)) != 32'd0) begin
         msb = msb + 6'd1;
      end
      return msb;
   endfunction

endpackage

// ===== sv/scba_bitmap_ram.sv =====
// Chunk bitmap store of the allocator: one word per row, row = frame and word.
// Registered (synchronous) read. Depends on scba_pkg.
module scba_bitmap_ram #(
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [scba_pkg::WORD_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [scba_pkg::WORD_BITS-1:0] rd_data
);
   import scba_pkg::*;

   logic [WORD_BITS-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/scba_frame_ram.sv =====
// Per-frame table of the allocator: class, creation stamp and used count.
// Registered (synchronous) read. Depends on scba_pkg.
module scba_frame_ram #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [scba_pkg::CLASS_W+scba_pkg::STAMP_W+scba_pkg::COUNT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [scba_pkg::CLASS_W+scba_pkg::STAMP_W+scba_pkg::COUNT_W-1:0] rd_data
);
   import scba_pkg::*;

   localparam int ENTRY_W = CLASS_W + STAMP_W + COUNT_W;

   logic [ENTRY_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/size_class_bitmap_allocator_core.sv =====
// Size-class bitmap allocator; depends on scba_pkg, scba_frame_ram and scba_bitmap_ram.
// After reset a clearing pass over all 2**ceil(log2(NUM_FRAMES)) rows zeroes the frame table
// while req_stall stays high. The bitmap rows are zeroed, but for the bit of the first
// chunk, when a frame becomes a run. An allocate beat scans the frame table one entry a
// cycle. It then either reads the run's bitmap words, a read and a check step per word,
// up to the first word with a clear bit, or clears the 64 words of a new run. A free
// beat reads the frame entry and the bitmap word, then writes the word back; a large or
// zero size goes straight to the result. The result waits in its register until the beat
// is taken, and the controller then returns to idle. One request is worked at a time.
module size_class_bitmap_allocator_core #(
   parameter int NUM_CLASSES = 11,
   parameter int NUM_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [19:0] csr_pool_base_page,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_req_type,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_chunk_address,
   output logic [3:0]  rsp_size_class
);
   import scba_pkg::*;

   localparam int FA_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int BA_W = FA_W + 6;
   localparam int ENTRY_W = CLASS_W + STAMP_W + COUNT_W;

   state_type state_ff, state_in;

   logic [PAGE_W-1:0]  base_ff;
   logic [STAMP_W-1:0] ctr_ff, ctr_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;
   logic [31:0]        addr_ff, addr_in;
   logic [FA_W-1:0]    idx_ff, idx_in;    // target frame
   logic [FA_W:0]      scan_ff, scan_in;
   logic               best_ok_ff, best_ok_in;
   logic [FA_W-1:0]    best_ff, best_in;
   logic [STAMP_W-1:0] best_age_ff, best_age_in;
   logic               free_ok_ff, free_ok_in;
   logic [FA_W-1:0]    free_f_ff, free_f_in;
   logic [5:0]         word_ff, word_in;
   logic [ENTRY_W-1:0] ent_ff, ent_in;    // entry of target frame
   logic [1:0]         st_ff, st_in;
   logic [31:0]        out_addr_ff, out_addr_in;
   logic [3:0]         out_cls_ff, out_cls_in;

   logic               fw_en;
   logic [FA_W-1:0]    fw_addr, fr_addr;
   logic [ENTRY_W-1:0] fw_data, fr_data;
   logic               bw_en;
   logic [BA_W-1:0]    bw_addr, br_addr;
   logic [WORD_BITS-1:0] bw_data, br_data;

   scba_frame_ram #(.ADDR_W(FA_W)) u_frames (
      .clock(clock), .wr_en(fw_en), .wr_addr(fw_addr), .wr_data(fw_data),
      .rd_addr(fr_addr), .rd_data(fr_data));

   scba_bitmap_ram #(.ADDR_W(BA_W)) u_bitmap (
      .clock(clock), .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
      .rd_addr(br_addr), .rd_data(br_data));

   logic [CLASS_W-1:0] rd_cls;
   logic [STAMP_W-1:0] rd_stamp, rd_age;
   logic [COUNT_W-1:0] rd_cnt, nchunks;
   logic [5:0]         req_cls6;
   logic [19:0]        rel_page;
   logic [4:0]         lowbit;
   logic               have_zero;
   logic [FA_W-1:0]    scan_rd;

   assign rd_cls = fr_data[ENTRY_W-1 -: CLASS_W];
   assign rd_stamp = fr_data[COUNT_W +: STAMP_W];
   assign rd_cnt = fr_data[COUNT_W-1:0];
   assign rd_age = ctr_ff - rd_stamp;
   assign nchunks = COUNT_W'(13'd4096 >> cls_ff);
   assign req_cls6 = class_of(req_request_size);
   assign rel_page = req_free_address[31:12] - base_ff;
   assign scan_rd = scan_ff[FA_W-1:0];

   // Lowest clear bit of the read word.
   always_comb begin
      lowbit = '0;
      have_zero = 1'b0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!br_data[i]) begin
            lowbit = 5'(i);
            have_zero = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr_en) begin
         base_ff <= csr_pool_base_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ctr_ff <= '0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         scan_ff <= scan_in;
      end
      cls_ff <= cls_in;
      addr_ff <= addr_in;
      idx_ff <= idx_in;
      best_ok_ff <= best_ok_in;
      best_ff <= best_in;
      best_age_ff <= best_age_in;
      free_ok_ff <= free_ok_in;
      free_f_ff <= free_f_in;
      word_ff <= word_in;
      ent_ff <= ent_in;
      st_ff <= st_in;
      out_addr_ff <= out_addr_in;
      out_cls_ff <= out_cls_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (scan_ff == (FA_W + 1)'(2**FA_W - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_req_type == REQ_FREE) begin
                  state_in = S_FREE_RD;
               end else if (req_request_size == 32'd0 || req_cls6 > 6'(NUM_CLASSES)) begin
                  state_in = S_RESP;
               end else if (NUM_FRAMES == 1) begin
                  state_in = S_SCAN_LAST;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff == (FA_W + 1)'(NUM_FRAMES - 1)) state_in = S_SCAN_LAST;
         end
         S_SCAN_LAST: begin
            priority if (best_ok_in) state_in = S_WORD_RD;
            else if (free_ok_in) state_in = S_NEW_CLR;
            else state_in = S_RESP;
         end
         S_WORD_RD: state_in = S_WORD_CHK;
         S_WORD_CHK: begin
            if (have_zero || word_ff == 6'd63) state_in = S_RESP;
            else state_in = S_WORD_RD;
         end
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_RESP;
         S_NEW_CLR: begin
            if (word_ff == 6'd63) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      ctr_in = ctr_ff;
      scan_in = scan_ff;
      cls_in = cls_ff;
      addr_in = addr_ff;
      idx_in = idx_ff;
      best_ok_in = best_ok_ff;
      best_in = best_ff;
      best_age_in = best_age_ff;
      free_ok_in = free_ok_ff;
      free_f_in = free_f_ff;
      word_in = word_ff;
      ent_in = ent_ff;
      st_in = st_ff;
      out_addr_in = out_addr_ff;
      out_cls_in = out_cls_ff;
      fw_en = 1'b0;
      fw_addr = idx_ff;
      fw_data = ent_ff;
      fr_addr = scan_rd;
      bw_en = 1'b0;
      bw_addr = {idx_ff, word_ff};
      bw_data = '0;
      br_addr = {idx_ff, word_ff};
      unique case (state_ff)
         S_CLEAR: begin
            fw_en = 1'b1;
            fw_addr = scan_rd;
            fw_data = '0;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (FA_W + 1)'(2**FA_W - 1)) scan_in = '0;
         end
         S_IDLE: begin
            cls_in = req_cls6[CLASS_W-1:0];
            addr_in = req_free_address;
            best_ok_in = 1'b0;
            free_ok_in = 1'b0;
            scan_in = '0;
            fr_addr = rel_page[FA_W-1:0];
            word_in = '0;
            st_in = ST_OK;
            out_addr_in = '0;
            out_cls_in = '0;
            if (req_valid && req_req_type == REQ_ALLOC &&
                (req_request_size == 32'd0 || req_cls6 > 6'(NUM_CLASSES))) begin
               st_in = ST_LARGE;
            end
            fr_addr = '0;
            if (req_req_type == REQ_FREE) fr_addr = rel_page[FA_W-1:0];
            idx_in = rel_page[FA_W-1:0];
            if (req_valid && req_req_type == REQ_FREE &&
                rel_page >= 20'(NUM_FRAMES)) begin
               st_in = ST_NOT_FOUND;
            end
            scan_in = (FA_W + 1)'(1);
            if (req_req_type == REQ_FREE) scan_in = '0;
         end
         S_SCAN, S_SCAN_LAST: begin
            // fr_data holds the entry of frame scan_ff - 1.
            fr_addr = scan_rd;
            if (state_ff == S_SCAN) scan_in = scan_ff + 1'b1;
            if (rd_cls == cls_ff && rd_cnt < nchunks &&
                (!best_ok_ff || rd_age < best_age_ff)) begin
               best_ok_in = 1'b1;
               best_in = FA_W'(scan_ff - 1'b1);
               best_age_in = rd_age;
               ent_in = fr_data;
            end
            if (rd_cls == '0 && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_f_in = FA_W'(scan_ff - 1'b1);
            end
            if (state_ff == S_SCAN_LAST) begin
               scan_in = '0;
               word_in = '0;
               if (best_ok_in) begin
                  idx_in = best_in;
               end else if (free_ok_in) begin
                  idx_in = free_f_in;
               end else begin
                  st_in = ST_NO_FRAME;
               end
            end
         end
         S_WORD_RD: begin
            br_addr = {idx_ff, word_ff};
         end
         S_WORD_CHK: begin
            if (have_zero) begin
               bw_en = 1'b1;
               bw_data = br_data | (WORD_BITS'(1) << lowbit);
               fw_en = 1'b1;
               fw_data = {ent_ff[ENTRY_W-1:COUNT_W], ent_ff[COUNT_W-1:0] + 1'b1};
               out_addr_in = {20'(base_ff + 20'(idx_ff)), 12'd0} +
                             (32'({word_ff, 5'd0} | 11'(lowbit)) << cls_ff);
               out_cls_in = cls_ff;
            end else if (word_ff == 6'd63) begin
               st_in = ST_NO_FRAME;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_FREE_RD: begin
            // Frame entry read is valid; fetch the bitmap word.
            ent_in = fr_data;
            br_addr = {idx_ff, 6'(32'(addr_ff[11:0] >> rd_cls) >> 5)};
            word_in = 6'(32'(addr_ff[11:0] >> rd_cls) >> 5);
            if (st_ff == ST_OK && rd_cls == '0) st_in = ST_NOT_FOUND;
         end
         S_FREE_WR: begin
            if (st_ff == ST_OK) begin
               out_cls_in = ent_ff[ENTRY_W-1 -: CLASS_W];
               if (br_data[5'(addr_ff[11:0] >> ent_ff[ENTRY_W-1 -: CLASS_W])]) begin
                  bw_en = 1'b1;
                  bw_data = br_data &
                     ~(WORD_BITS'(1) << 5'(addr_ff[11:0] >> ent_ff[ENTRY_W-1 -: CLASS_W]));
                  fw_en = 1'b1;
                  if (ent_ff[COUNT_W-1:0] == COUNT_W'(1)) fw_data = '0;
                  else fw_data = {ent_ff[ENTRY_W-1:COUNT_W], ent_ff[COUNT_W-1:0] - 1'b1};
               end
            end
         end
         S_NEW_CLR: begin
            bw_en = 1'b1;
            bw_data = (word_ff == 6'd0) ? WORD_BITS'(1) : '0;
            word_in = word_ff + 1'b1;
            if (word_ff == 6'd63) begin
               fw_en = 1'b1;
               fw_data = {cls_ff, ctr_ff, COUNT_W'(1)};
               ctr_in = ctr_ff + 1'b1;
               out_addr_in = {20'(base_ff + 20'(idx_ff)), 12'd0};
               out_cls_in = cls_ff;
            end
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_chunk_address = out_addr_ff;
   assign rsp_size_class = out_cls_ff;

endmodule

// ===== bench/alloc_checker.sv =====
// Checker for the size-class bitmap allocator: predicts every result beat from
// the accepted request beats and compares. Depends on scba_pkg.
module alloc_checker #(
   parameter int NUM_CLASSES = 11,
   parameter int NUM_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [19:0] csr_pool_base_page,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_req_type,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_free_address,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_chunk_address,
   input  logic [3:0]  rsp_size_class,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import scba_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] addr;
      logic [3:0]  cls;
   } alloc_result_type;

   alloc_result_type expected_results[$];

   logic [19:0] base_page;
   logic [3:0]  run_class[NUM_FRAMES];
   logic [15:0] run_stamp[NUM_FRAMES];
   logic [15:0] run_counter;
   logic [11:0] run_used[NUM_FRAMES];
   logic [4095:0] run_bits[NUM_FRAMES];

   function automatic logic [31:0] frame_base(int f);
      logic [19:0] page;
      page = base_page + 20'(f);
      return {page, 12'h000};
   endfunction

   function automatic alloc_result_type predict_alloc(logic [31:0] size);
      alloc_result_type r;
      int msb, cls, n, best;
      logic [15:0] age, best_age;
      r = '0;
      msb = 0;
      best = -1;
      best_age = '0;
      if (size == 0) begin
         r.status = ST_LARGE;
         return r;
      end
      for (int i = 0; i < 32; i++) if (size[i]) msb = i;
      cls = msb;
      if (msb == 0 || size > (32'd1 << msb)) cls++;
      if (cls > NUM_CLASSES) begin
         r.status = ST_LARGE;
         return r;
      end
      n = 4096 >> cls;
      for (int f = 0; f < NUM_FRAMES; f++) begin
         if (run_class[f] == 4'(cls) && run_used[f] < 12'(n)) begin
            age = run_counter - run_stamp[f];
            if (best < 0 || age < best_age) begin
               best = f;
               best_age = age;
            end
         end
      end
      if (best >= 0) begin
         for (int i = 0; i < n; i++) begin
            if (!run_bits[best][i]) begin
               run_bits[best][i] = 1'b1;
               run_used[best]++;
               r.status = ST_OK;
               r.addr = frame_base(best) + 32'(i << cls);
               r.cls = 4'(cls);
               return r;
            end
         end
         r.status = ST_NO_FRAME;
         return r;
      end
      for (int f = 0; f < NUM_FRAMES; f++) begin
         if (run_class[f] == 0) begin
            run_bits[f] = '0;
            run_bits[f][0] = 1'b1;
            run_class[f] = 4'(cls);
            run_stamp[f] = run_counter;
            run_counter++;
            run_used[f] = 12'd1;
            r.status = ST_OK;
            r.addr = frame_base(f);
            r.cls = 4'(cls);
            return r;
         end
      end
      r.status = ST_NO_FRAME;
      return r;
   endfunction

   function automatic alloc_result_type predict_free(logic [31:0] addr);
      alloc_result_type r;
      logic [19:0] rel;
      int cls, idx;
      r = '0;
      rel = addr[31:12] - base_page;
      if (rel >= 20'(NUM_FRAMES) || run_class[rel] == 0) begin
         r.status = ST_NOT_FOUND;
         return r;
      end
      cls = run_class[rel];
      idx = int'(addr[11:0]) >> cls;
      if (idx < (4096 >> cls) && run_bits[rel][idx]) begin
         run_bits[rel][idx] = 1'b0;
         run_used[rel]--;
         if (run_used[rel] == 0) begin
            run_class[rel] = '0;
            run_stamp[rel] = '0;
         end
      end
      r.status = ST_OK;
      r.cls = 4'(cls);
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (reset) begin
         base_page <= '0;
         run_counter = '0;
         for (int f = 0; f < NUM_FRAMES; f++) begin
            run_class[f] = '0;
            run_stamp[f] = '0;
            run_used[f] = '0;
            run_bits[f] = '0;
         end
         expected_results.delete();
         error_count <= 0;
      end else begin
         if (csr_wr_en) base_page <= csr_pool_base_page;
         if (req_valid && !req_stall) begin
            if (req_req_type == REQ_ALLOC)
               expected_results.push_back(predict_alloc(req_request_size));
            else
               expected_results.push_back(predict_free(req_free_address));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected");
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_status !== exp_r.status || rsp_chunk_address !== exp_r.addr
                   || rsp_size_class !== exp_r.cls) begin
                  error_count <= error_count + 1;
                  if (rsp_status !== exp_r.status)
                     $error("status expected %0d actual %0d", exp_r.status, rsp_status);
                  if (rsp_chunk_address !== exp_r.addr)
                     $error("chunk_address expected %h actual %h", exp_r.addr,
                            rsp_chunk_address);
                  if (rsp_size_class !== exp_r.cls)
                     $error("size_class expected %0d actual %0d", exp_r.cls,
                            rsp_size_class);
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb.sv =====
// Top of the allocator testbench: clock, reset, stimulus and verdict.
// Depends on scba_pkg, size_class_bitmap_allocator_core and alloc_checker.
module tb;
   import scba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [19:0] csr_pool_base_page = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_req_type = REQ_ALLOC;
   logic [31:0] req_request_size = '0;
   logic [31:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_chunk_address;
   logic [3:0]  rsp_size_class;
   int          error_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic [31:0] live_addrs[$];

   size_class_bitmap_allocator_core DUT (.*);
   alloc_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Remember granted chunks so that most frees hit live runs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_OK && rsp_chunk_address != 0
          && live_addrs.size() < 400)
         live_addrs.push_back(rsp_chunk_address);
   end

   // Valid stays high after a beat is taken when the next beat follows at once.
   task automatic send_beat(logic kind, logic [31:0] size, logic [31:0] addr);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= kind;
      req_request_size <= size;
      req_free_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_base(logic [19:0] page);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_pool_base_page <= page;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_beat();
      int pick;
      logic [31:0] a;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_beat(REQ_ALLOC, 32'($urandom_range(2048, 1) >> $urandom_range(10)), $urandom);
      end else if (pick < 85 && live_addrs.size() > 0) begin
         a = live_addrs[$urandom_range(live_addrs.size() - 1)];
         if ($urandom_range(3) == 0) a = a ^ 32'($urandom_range(4095));
         send_beat(REQ_FREE, $urandom, a);
      end else if (pick < 92) begin
         send_beat(REQ_ALLOC, $urandom, $urandom);
      end else begin
         send_beat(REQ_FREE, $urandom, {csr_pool_base_page + 20'($urandom_range(80)),
                   12'($urandom)});
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Directed: size edges, large sizes, frees outside the pool and of free chunks.
      send_beat(REQ_ALLOC, 32'd0, '0);
      send_beat(REQ_ALLOC, 32'd1, '0);
      send_beat(REQ_ALLOC, 32'd2, '0);
      send_beat(REQ_ALLOC, 32'd3, '0);
      send_beat(REQ_ALLOC, 32'd2048, '0);
      send_beat(REQ_ALLOC, 32'd2049, '0);
      send_beat(REQ_ALLOC, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(REQ_ALLOC, 32'h8000_0000, '0);
      send_beat(REQ_ALLOC, 32'd2048, '0);
      send_beat(REQ_ALLOC, 32'd2048, '0);
      send_beat(REQ_FREE, '0, 32'h0000_0002);
      send_beat(REQ_FREE, '0, 32'h0000_0002);
      send_beat(REQ_FREE, '0, 32'h0000_1800);
      send_beat(REQ_FREE, '0, 32'h0000_1000);
      send_beat(REQ_FREE, '0, 32'hffff_ffff);
      send_beat(REQ_FREE, 32'hffff_ffff, 32'h0004_0000);
      send_beat(REQ_FREE, '0, 32'h0000_3000);
      // Fill the pool with large runs to hit the pool-full case.
      repeat (130) send_beat(REQ_ALLOC, 32'd1025, '0);
      drain_all();
      set_base(20'hfffff);
      for (int i = 0; i < 66; i++) send_beat(REQ_FREE, '0, {20'hfffff + 20'(i / 2),
         12'(i % 2) << 11});
      live_addrs.delete();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 51; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 51; end
            3: begin send_idle_pct = 27; stall_pct = 27; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if (phase == 2) begin
            set_base(20'h12345);
            live_addrs.delete();
         end
         if (phase == 4) begin
            set_base(20'h00000);
            live_addrs.delete();
         end
         repeat (90) random_beat();
      end
      drain_all();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: errors");
      $finish;
   end
endmodule

// ===== sim.f =====
sv/scba_pkg.sv
sv/scba_bitmap_ram.sv
sv/scba_frame_ram.sv
sv/size_class_bitmap_allocator_core.sv
bench/alloc_checker.sv
bench/tb.sv
